### hdl/lhrg_pkg.sv
// Shared types, codes and constants for the latency histogram rate governor.
package lhrg_pkg;

    localparam int RATE_W      = 24;
    localparam int MS_W        = 16;
    localparam int P95_W       = 11;
    localparam int LAT_W       = 32;
    localparam int OUT_CNT_W   = 32;
    localparam int NUM_BUCKETS = 5;
    localparam int BKT_IDX_W   = 3;
    localparam int DIV_NUM_W   = 49;
    localparam int DIV_CNT_W   = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // Reciprocal of ten for the rate step: floor(x * RECIP10 / 2^30) == x / 10 for x < 2^26
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 30;
    localparam int NR_NUM_W    = RATE_W + 2;
    localparam int NR_PROD_W   = NR_NUM_W + RECIP_W + 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_RATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_BURST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_MS = 3'd4;

    // Mode codes
    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_THROTTLE = 2'd1;
    localparam logic [1:0] MODE_PROTECT  = 2'd2;

    localparam logic [RATE_W-1:0]  RESET_BASE_RATE  = 24'd1000;
    localparam logic [RATE_W-1:0]  RESET_BASE_BURST = 24'd1000;
    localparam logic [MS_W-1:0]    RESET_TARGET_MS  = 16'd200;
    localparam logic [MS_W-1:0]    RESET_PROTECT_MS = 16'd1000;
    localparam logic [RECIP_W-1:0] RECIP10          = 27'd107374183;
    localparam logic [RATE_W-1:0]  RATE_MAX         = 24'hFFFFFF;

    // Bucket edges in microseconds (10, 50, 200 and 1000 ms)
    localparam logic [LAT_W-1:0] EDGE_US_0 = 32'd10000;
    localparam logic [LAT_W-1:0] EDGE_US_1 = 32'd50000;
    localparam logic [LAT_W-1:0] EDGE_US_2 = 32'd200000;
    localparam logic [LAT_W-1:0] EDGE_US_3 = 32'd1000000;

    typedef logic [BKT_IDX_W-1:0] t_bucket_idx;

    typedef struct packed {
        logic             func;
        logic [LAT_W-1:0] lat_usec;
    } t_in_item;

    typedef struct packed {
        logic                 adjusted;
        logic [1:0]           mode;
        logic [RATE_W-1:0]    new_rate;
        logic [RATE_W-1:0]    scaled_burst;
        logic [P95_W-1:0]     p95_ms;
        logic [OUT_CNT_W-1:0] window_count;
        logic [OUT_CNT_W-1:0] adjust_count;
        logic [OUT_CNT_W-1:0] throttle_count;
        logic [OUT_CNT_W-1:0] protect_count;
    } t_out_item;

    typedef struct packed {
        logic obs;
        logic clear;
        logic scan;
    } t_hist_ctl;

    typedef struct packed {
        logic             done;
        logic [P95_W-1:0] p95;
    } t_hist_sts;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [RATE_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_sts;

    function automatic t_bucket_idx bucket_of(input logic [LAT_W-1:0] lat_us);
        t_bucket_idx b;
        if (lat_us < EDGE_US_0)      b = 3'd0;
        else if (lat_us < EDGE_US_1) b = 3'd1;
        else if (lat_us < EDGE_US_2) b = 3'd2;
        else if (lat_us < EDGE_US_3) b = 3'd3;
        else                         b = 3'd4;
        return b;
    endfunction

    function automatic logic [P95_W-1:0] mid_ms(input t_bucket_idx idx);
        logic [P95_W-1:0] m;
        case (idx)
            3'd0:    m = 11'd5;
            3'd1:    m = 11'd30;
            3'd2:    m = 11'd125;
            3'd3:    m = 11'd600;
            default: m = 11'd2000;
        endcase
        return m;
    endfunction

endpackage

### hdl/lhrg_div.sv
// Restoring divider, one quotient bit per cycle.
module lhrg_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lhrg_pkg::t_div_req i_req,
    output lhrg_pkg::t_div_sts o_sts
);
    import lhrg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [RATE_W-1:0]    r_rem;
    logic [RATE_W-1:0]    r_dvs;

    logic [RATE_W:0] trial;
    logic [RATE_W:0] diff;
    logic            fits;
    logic            last;

    always_comb begin
        trial = {r_rem, r_quo[DIV_NUM_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
        last  = (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                // shift in the next dividend bit, subtract when it fits
                r_rem  <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
                r_quo  <= {r_quo[DIV_NUM_W-2:0], fits};
                r_cnt  <= r_cnt + 1'b1;
                r_done <= last;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.quotient = r_quo;

endmodule

### hdl/lhrg_hist.sv
// Bucket counters, window count and the sequential p95 bucket scan.
module lhrg_hist #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lhrg_pkg::t_hist_ctl     i_ctl,
    input  lhrg_pkg::t_bucket_idx   i_bucket,
    output lhrg_pkg::t_hist_sts     o_sts,
    output logic [COUNT_WIDTH-1:0]  o_window_total
);
    import lhrg_pkg::*;

    localparam int SUM_W = COUNT_WIDTH + 3;
    localparam int ACC_W = COUNT_WIDTH + 9;

    typedef enum logic [1:0] {
        H_IDLE,
        H_INIT,
        H_SCAN
    } t_hstate;

    t_hstate               r_state;
    logic [COUNT_WIDTH-1:0] r_bkt [NUM_BUCKETS];
    logic [COUNT_WIDTH-1:0] r_total;
    logic [SUM_W-1:0]       r_sum;
    logic [ACC_W-1:0]       r_acc;
    t_bucket_idx            r_idx;
    logic                   r_done;
    logic [P95_W-1:0]       r_p95;

    logic [ACC_W-1:0] sum_ext;
    logic [ACC_W-1:0] bkt_ext;
    logic [ACC_W-1:0] n_acc;
    logic [ACC_W-1:0] neg_t19;
    logic             bkt_sat;

    always_comb begin
        sum_ext = ACC_W'(r_sum);
        bkt_ext = ACC_W'(r_bkt[r_idx]);
        // 20*cum - 19*total >= 0 is the same test as 100*cum >= 95*total
        neg_t19 = '0 - ((sum_ext << 4) + (sum_ext << 1) + sum_ext);
        n_acc   = r_acc + (bkt_ext << 4) + (bkt_ext << 2);
        bkt_sat = (r_bkt[i_bucket] == '1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_total <= '0;
            r_sum   <= '0;
            r_done  <= 1'b0;
            r_p95   <= '0;
            r_idx   <= '0;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                r_bkt[i] <= '0;
            end
        end else begin
            if (i_ctl.clear) begin
                r_total <= '0;
                r_sum   <= '0;
                for (int i = 0; i < NUM_BUCKETS; i++) begin
                    r_bkt[i] <= '0;
                end
            end else if (i_ctl.obs) begin
                if (r_total != '1) begin
                    r_total <= r_total + 1'b1;
                end
                if (!bkt_sat) begin
                    r_sum <= r_sum + 1'b1;
                end
                for (int i = 0; i < NUM_BUCKETS; i++) begin
                    if (i_bucket == BKT_IDX_W'(i) && !bkt_sat) begin
                        r_bkt[i] <= r_bkt[i] + 1'b1;
                    end
                end
            end

            case (r_state)
                H_IDLE: begin
                    r_done <= 1'b0;
                    if (i_ctl.scan) begin
                        r_state <= H_INIT;
                    end
                end
                H_INIT: begin
                    r_idx  <= '0;
                    r_acc  <= neg_t19;
                    r_done <= (r_sum == '0);
                    if (r_sum == '0) begin
                        r_p95   <= '0;
                        r_state <= H_IDLE;
                    end else begin
                        r_state <= H_SCAN;
                    end
                end
                H_SCAN: begin
                    r_acc  <= n_acc;
                    r_idx  <= r_idx + 1'b1;
                    r_done <= !n_acc[ACC_W-1];
                    // the last bucket always qualifies once the sum is nonzero
                    if (!n_acc[ACC_W-1]) begin
                        r_p95   <= mid_ms(r_idx);
                        r_state <= H_IDLE;
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.p95      = r_p95;
    assign o_window_total = r_total;

endmodule

### hdl/latency_histogram_rate_governor_core.sv
// Top level: item sequencer, rate decision, burst scaling and result register.
// Steps: every transaction waits for the p95 scan (one bucket a cycle) before its result; an
//   enabled tick also picks the mode and, when the rate changes, runs a restoring burst divide.
// Throughput: one transaction at a time; the next is taken the cycle after the result is
//   registered, and a result held by the receiver stalls the item behind it in its last step.
// Reset (synchronous, active low) clears histogram and counters and loads register defaults.
module latency_histogram_rate_governor_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  lhrg_pkg::t_in_item                     i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output lhrg_pkg::t_out_item                    o_out_data,
    input  logic                                   i_cfg_we,
    input  logic [lhrg_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [lhrg_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import lhrg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_P95,
        S_MODE,
        S_CMP,
        S_MUL,
        S_BDIV,
        S_FIN
    } t_state;

    t_state r_state;

    logic              r_enable;
    logic [RATE_W-1:0] r_base_rate;
    logic [RATE_W-1:0] r_base_burst;
    logic [MS_W-1:0]   r_target_ms;
    logic [MS_W-1:0]   r_protect_ms;

    logic [RATE_W-1:0]      r_cur_rate;
    logic [COUNT_WIDTH-1:0] r_adjustments;
    logic [COUNT_WIDTH-1:0] r_throttles;
    logic [COUNT_WIDTH-1:0] r_protects;

    logic                  r_func;
    logic                  r_clr;
    logic                  r_adj;
    logic [1:0]            r_mode;
    logic [P95_W-1:0]      r_p95;
    logic [RATE_W-1:0]     r_nr;
    logic [RATE_W-1:0]     r_burst;
    logic [2*RATE_W-1:0]   r_prod;

    logic      r_out_valid;
    t_out_item r_out;

    t_hist_ctl              hist_ctl;
    t_hist_sts              hist_sts;
    logic [COUNT_WIDTH-1:0] window_total;
    t_div_req               div_req;
    t_div_sts               div_sts;

    logic                 in_acc;
    logic                 out_take;
    logic                 fin_load;
    logic [1:0]           mode_sel;
    logic [RATE_W-1:0]    nr1;
    logic [RATE_W-1:0]    base_div;
    logic [RATE_W-1:0]    burst_clamped;
    logic [MS_W-1:0]      p95_ext;
    logic [NR_NUM_W-1:0]  nr_num;
    logic [NR_PROD_W-1:0] nr_prod;
    logic [RATE_W-1:0]    nr_div10;

    function automatic logic [OUT_CNT_W-1:0] low32(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_CNT_W-1:0];
    endfunction

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_take = r_out_valid && !i_out_stall;
    assign fin_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    always_comb begin
        p95_ext = MS_W'(r_p95);
        if (p95_ext >= r_protect_ms)     mode_sel = MODE_PROTECT;
        else if (p95_ext >= r_target_ms) mode_sel = MODE_THROTTLE;
        else                             mode_sel = MODE_NORMAL;

        // divide the base rate (times four when throttling) by ten with a reciprocal multiply
        nr_num   = (mode_sel == MODE_THROTTLE) ? {r_base_rate, 2'b00} : {2'b00, r_base_rate};
        nr_prod  = NR_PROD_W'(nr_num) * NR_PROD_W'(RECIP10);
        nr_div10 = nr_prod[RECIP_SHIFT +: RATE_W];

        nr1      = (r_nr == '0) ? RATE_W'(1) : r_nr;
        base_div = (r_base_rate == '0) ? RATE_W'(1) : r_base_rate;

        if (div_sts.quotient == '0)                           burst_clamped = RATE_W'(1);
        else if (div_sts.quotient > DIV_NUM_W'(RATE_MAX))     burst_clamped = RATE_MAX;
        else                                                  burst_clamped =
                                                              div_sts.quotient[RATE_W-1:0];
    end

    always_comb begin
        // add half the divisor to round to nearest
        div_req.start    = (r_state == S_MUL);
        div_req.dividend = DIV_NUM_W'(r_prod) + DIV_NUM_W'(base_div >> 1);
        div_req.divisor  = base_div;
    end

    always_comb begin
        hist_ctl.obs   = in_acc && !i_in_data.func;
        hist_ctl.scan  = in_acc;
        hist_ctl.clear = fin_load && r_clr;
    end

    lhrg_hist #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_hist (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (hist_ctl),
        .i_bucket       (bucket_of(i_in_data.lat_usec)),
        .o_sts          (hist_sts),
        .o_window_total (window_total)
    );

    lhrg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_sts   (div_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_enable      <= 1'b0;
            r_base_rate   <= RESET_BASE_RATE;
            r_base_burst  <= RESET_BASE_BURST;
            r_target_ms   <= RESET_TARGET_MS;
            r_protect_ms  <= RESET_PROTECT_MS;
            r_cur_rate    <= RESET_BASE_RATE;
            r_adjustments <= '0;
            r_throttles   <= '0;
            r_protects    <= '0;
            r_out_valid   <= 1'b0;
            r_clr         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE:     r_enable     <= i_cfg_data[0];
                    CFG_BASE_RATE: begin
                        r_base_rate <= i_cfg_data;
                        r_cur_rate  <= (i_cfg_data == '0) ? RATE_W'(1) : i_cfg_data;
                    end
                    CFG_BASE_BURST: r_base_burst <= i_cfg_data;
                    CFG_TARGET_MS:  r_target_ms  <= i_cfg_data[MS_W-1:0];
                    CFG_PROTECT_MS: r_protect_ms <= i_cfg_data[MS_W-1:0];
                    default: ;
                endcase
            end

            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_func  <= i_in_data.func;
                        r_clr   <= 1'b0;
                        r_adj   <= 1'b0;
                        r_mode  <= MODE_NORMAL;
                        r_burst <= '0;
                        r_state <= S_P95;
                    end
                end
                S_P95: begin
                    if (hist_sts.done) begin
                        r_p95   <= hist_sts.p95;
                        r_state <= (r_func && r_enable) ? S_MODE : S_FIN;
                    end
                end
                S_MODE: begin
                    r_mode  <= mode_sel;
                    r_clr   <= 1'b1;
                    r_state <= S_CMP;
                    case (mode_sel)
                        MODE_PROTECT: begin
                            if (r_protects != '1) r_protects <= r_protects + 1'b1;
                            r_nr <= nr_div10;
                        end
                        MODE_THROTTLE: begin
                            if (r_throttles != '1) r_throttles <= r_throttles + 1'b1;
                            r_nr <= nr_div10;
                        end
                        default: begin
                            r_nr <= r_base_rate;
                        end
                    endcase
                end
                S_CMP: begin
                    r_nr <= nr1;
                    if (nr1 != r_cur_rate) begin
                        r_prod  <= (2*RATE_W)'(r_base_burst) * (2*RATE_W)'(nr1);
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_MUL: begin
                    r_state <= S_BDIV;
                end
                S_BDIV: begin
                    if (div_sts.done) begin
                        r_burst    <= burst_clamped;
                        r_cur_rate <= r_nr;
                        r_adj      <= 1'b1;
                        if (r_adjustments != '1) r_adjustments <= r_adjustments + 1'b1;
                        r_state    <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold until the result register is free
                    if (fin_load) begin
                        r_out.adjusted       <= r_adj;
                        r_out.mode           <= r_mode;
                        r_out.new_rate       <= r_cur_rate;
                        r_out.scaled_burst   <= r_burst;
                        r_out.p95_ms         <= r_p95;
                        r_out.window_count   <= r_clr ? '0 : low32(window_total);
                        r_out.adjust_count   <= low32(r_adjustments);
                        r_out.throttle_count <= low32(r_throttles);
                        r_out.protect_count  <= low32(r_protects);
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_acc_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("sequencer did not leave idle after a transaction");

    a_rate_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_rate != '0)
        else $error("current rate dropped to zero");

    a_adj_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.adjusted) |-> (o_out_data.scaled_burst != '0))
        else $error("adjusted result carries a zero burst");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> (r_state == S_BDIV))
        else $error("divider finished outside the burst divide step");

    a_scan_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_sts.done |-> (r_state == S_P95))
        else $error("p95 scan finished outside the scan wait");

endmodule

### tb/sv/tb_latency_histogram_rate_governor_core.sv
// Self-checking testbench for the latency histogram rate governor core.
`timescale 1ns / 100ps

module tb_latency_histogram_rate_governor_core;
    import lhrg_pkg::*;

class rate_governor_scoreboard;
    localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;

    logic [31:0]       hist_bins [NUM_BUCKETS];
    logic [31:0]       window_obs;
    logic [RATE_W-1:0] cur_rate;
    logic [31:0]       rate_changes;
    logic [31:0]       throttle_ticks;
    logic [31:0]       protect_ticks;

    logic              gov_enable;
    logic [RATE_W-1:0] base_rate;
    logic [RATE_W-1:0] base_burst;
    logic [MS_W-1:0]   target_ms;
    logic [MS_W-1:0]   protect_ms;

    t_out_item expected_q [$];
    int        mismatches;

    function new();
        for (int i = 0; i < NUM_BUCKETS; i++) hist_bins[i] = '0;
        window_obs     = '0;
        cur_rate       = 24'd1000;
        rate_changes   = '0;
        throttle_ticks = '0;
        protect_ticks  = '0;
        gov_enable     = 1'b0;
        base_rate      = 24'd1000;
        base_burst     = 24'd1000;
        target_ms      = 16'd200;
        protect_ms     = 16'd1000;
        mismatches     = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function logic [31:0] bump(input logic [31:0] v);
        return (v == CNT_SAT) ? v : v + 32'd1;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_ENABLE:     gov_enable = val[0];
            CFG_BASE_RATE: begin
                base_rate = val[RATE_W-1:0];
                cur_rate  = (val == '0) ? 24'd1 : val[RATE_W-1:0];
            end
            CFG_BASE_BURST: base_burst = val[RATE_W-1:0];
            CFG_TARGET_MS:  target_ms  = val[MS_W-1:0];
            CFG_PROTECT_MS: protect_ms = val[MS_W-1:0];
            default: ;
        endcase
    endfunction

    // Midpoint of the first bucket whose running share reaches 95 percent.
    function logic [P95_W-1:0] p95_midpoint();
        logic [63:0]      total;
        logic [63:0]      running;
        logic [P95_W-1:0] mids [NUM_BUCKETS];
        mids[0] = 11'd5;
        mids[1] = 11'd30;
        mids[2] = 11'd125;
        mids[3] = 11'd600;
        mids[4] = 11'd2000;
        total   = '0;
        running = '0;
        for (int i = 0; i < NUM_BUCKETS; i++) total += 64'(hist_bins[i]);
        if (total == 0) return '0;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            running += 64'(hist_bins[i]);
            if (running * 100 >= total * 95) return mids[i];
        end
        return mids[NUM_BUCKETS-1];
    endfunction

    function void note_input(input t_in_item it);
        t_out_item  r;
        logic [31:0] lat_ms;
        int          bin;
        logic [63:0] next_rate;
        logic [63:0] divisor;
        logic [63:0] burst;
        r = '0;
        if (it.func == 1'b0) begin
            lat_ms = it.lat_usec / 1000;
            if (lat_ms < 10)        bin = 0;
            else if (lat_ms < 50)   bin = 1;
            else if (lat_ms < 200)  bin = 2;
            else if (lat_ms < 1000) bin = 3;
            else                    bin = 4;
            hist_bins[bin] = bump(hist_bins[bin]);
            window_obs     = bump(window_obs);
            r.p95_ms       = p95_midpoint();
        end else begin
            r.p95_ms = p95_midpoint();
            if (gov_enable) begin
                next_rate = 64'(base_rate);
                if (32'(r.p95_ms) >= 32'(protect_ms)) begin
                    next_rate     = 64'(base_rate) / 10;
                    r.mode        = MODE_PROTECT;
                    protect_ticks = bump(protect_ticks);
                end else if (32'(r.p95_ms) >= 32'(target_ms)) begin
                    next_rate      = (64'(base_rate) * 4) / 10;
                    r.mode         = MODE_THROTTLE;
                    throttle_ticks = bump(throttle_ticks);
                end
                if (next_rate < 1) next_rate = 1;
                if (next_rate != 64'(cur_rate)) begin
                    divisor = (base_rate == '0) ? 64'd1 : 64'(base_rate);
                    burst   = (64'(base_burst) * next_rate + divisor / 2) / divisor;
                    if (burst < 1) burst = 1;
                    if (burst > 64'(RATE_MAX)) burst = 64'(RATE_MAX);
                    r.scaled_burst = burst[RATE_W-1:0];
                    cur_rate       = next_rate[RATE_W-1:0];
                    rate_changes   = bump(rate_changes);
                    r.adjusted     = 1'b1;
                end
                for (int i = 0; i < NUM_BUCKETS; i++) hist_bins[i] = '0;
                window_obs = '0;
            end
        end
        r.new_rate       = cur_rate;
        r.window_count   = window_obs;
        r.adjust_count   = rate_changes;
        r.throttle_count = throttle_ticks;
        r.protect_count  = protect_ticks;
        expected_q.push_back(r);
    endfunction

    function void field_miss(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %0d, got %0d", name, exp_v, act_v);
    endfunction

    function void check_result(input t_out_item act);
        t_out_item e;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: result transaction with nothing expected: %h", act);
            return;
        end
        e = expected_q.pop_front();
        if (act.adjusted !== e.adjusted)
            field_miss("adjusted", 32'(e.adjusted), 32'(act.adjusted));
        if (act.mode !== e.mode)
            field_miss("mode", 32'(e.mode), 32'(act.mode));
        if (act.new_rate !== e.new_rate)
            field_miss("new_rate", 32'(e.new_rate), 32'(act.new_rate));
        if (act.scaled_burst !== e.scaled_burst)
            field_miss("scaled_burst", 32'(e.scaled_burst), 32'(act.scaled_burst));
        if (act.p95_ms !== e.p95_ms)
            field_miss("p95_ms", 32'(e.p95_ms), 32'(act.p95_ms));
        if (act.window_count !== e.window_count)
            field_miss("window_count", e.window_count, act.window_count);
        if (act.adjust_count !== e.adjust_count)
            field_miss("adjust_count", e.adjust_count, act.adjust_count);
        if (act.throttle_count !== e.throttle_count)
            field_miss("throttle_count", e.throttle_count, act.throttle_count);
        if (act.protect_count !== e.protect_count)
            field_miss("protect_count", e.protect_count, act.protect_count);
    endfunction
endclass

    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 150;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 96;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    rate_governor_scoreboard sb = new();

    latency_histogram_rate_governor_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Monitor both channels and watch for lack of progress.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) sb.check_result(out_data);
            if (in_valid && !in_stall) sb.note_input(in_data);
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_latency_histogram_rate_governor_core failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic func, input logic [LAT_W-1:0] lat_us);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        in_data.func     <= func;
        in_data.lat_usec <= lat_us;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Hold the sender until every expected result is back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        // let the monitor record the last accepted transaction first
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [4:0] mask, input logic en,
                                input logic [23:0] rate, input logic [23:0] burst,
                                input logic [15:0] tgt, input logic [15:0] prot);
        logic [CFG_IDX_W-1:0]  reg_idx [5];
        logic [CFG_DATA_W-1:0] reg_val [5];
        reg_idx[0] = CFG_ENABLE;     reg_val[0] = 24'(en);
        reg_idx[1] = CFG_BASE_RATE;  reg_val[1] = rate;
        reg_idx[2] = CFG_BASE_BURST; reg_val[2] = burst;
        reg_idx[3] = CFG_TARGET_MS;  reg_val[3] = 24'(tgt);
        reg_idx[4] = CFG_PROTECT_MS; reg_val[4] = 24'(prot);
        for (int i = 0; i < 5; i++) begin
            if (mask[i]) begin
                cfg_we   <= 1'b1;
                cfg_idx  <= reg_idx[i];
                cfg_data <= reg_val[i];
                sb.write_reg(reg_idx[i], reg_val[i]);
                @(posedge clk);
            end
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [LAT_W-1:0] latency_in_bin(input int bin);
        logic [LAT_W-1:0] lo_us [5];
        logic [LAT_W-1:0] hi_us [5];
        int               pick;
        lo_us[0] = 32'd0;       hi_us[0] = 32'd9999;
        lo_us[1] = 32'd10000;   hi_us[1] = 32'd49999;
        lo_us[2] = 32'd50000;   hi_us[2] = 32'd199999;
        lo_us[3] = 32'd200000;  hi_us[3] = 32'd999999;
        lo_us[4] = 32'd1000000; hi_us[4] = 32'hFFFF_FFFF;
        pick = $urandom_range(19);
        if (pick == 0) return lo_us[bin];
        if (pick == 1) return hi_us[bin];
        return $urandom_range(hi_us[bin], lo_us[bin]);
    endfunction

    function automatic logic [15:0] pick_ms();
        logic [15:0] marks [12];
        int          sel;
        marks = '{16'd0, 16'd5, 16'd6, 16'd30, 16'd31, 16'd125,
                  16'd126, 16'd600, 16'd601, 16'd2000, 16'd2001, 16'hFFFF};
        sel = $urandom_range(13);
        if (sel >= 12) return 16'($urandom_range(2500));
        return marks[sel];
    endfunction

    // One window: a few observations around a dominant bucket, then a tick.
    task automatic run_window(output int used);
        int n;
        int dom;
        int noise_pct;
        int r;
        r = $urandom_range(99);
        if (r < 8)       n = 0;
        else if (r < 90) n = $urandom_range(12, 1);
        else             n = $urandom_range(40, 13);
        dom       = $urandom_range(4);
        noise_pct = $urandom_range(10);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 4)
                send_item(1'b0, $urandom());
            else if (r < 4 + noise_pct)
                send_item(1'b0, latency_in_bin($urandom_range(4)));
            else
                send_item(1'b0, latency_in_bin(dom));
        end
        send_item(1'b1, $urandom());
        used = n + 1;
    endtask

    initial begin
        logic [23:0] rates [9];
        logic [23:0] bursts [5];
        logic [4:0]  mask;
        int          sent;
        int          used;

        rates  = '{24'd0, 24'd1, 24'd5, 24'd9, 24'd10, 24'd11, 24'd1000, 24'hFFFFFF, 24'd77};
        bursts = '{24'd0, 24'd1, 24'd1000, 24'hFFFFFF, 24'd3};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: disabled ticks, bucket edges, normal and throttle modes, floors and extremes.
        send_item(1'b1, 32'd0);
        send_item(1'b0, 32'd0);
        send_item(1'b0, 32'd9999);
        send_item(1'b0, 32'd10000);
        send_item(1'b0, 32'd49999);
        send_item(1'b0, 32'd50000);
        send_item(1'b0, 32'd199999);
        send_item(1'b0, 32'd200000);
        send_item(1'b0, 32'd999999);
        send_item(1'b0, 32'd1000000);
        send_item(1'b0, 32'hFFFF_FFFF);
        send_item(1'b1, 32'hFFFF_FFFF);
        wait_idle();
        program_regs(5'b11111, 1'b1, 24'd1000, 24'd1000, 16'd200, 16'd1000);
        send_item(1'b1, 32'd0);
        send_item(1'b1, 32'd0);
        send_item(1'b0, 32'd5000);
        send_item(1'b1, 32'd0);
        send_item(1'b0, 32'd300000);
        send_item(1'b1, 32'd0);
        wait_idle();
        program_regs(5'b11111, 1'b1, 24'd0, 24'hFFFFFF, 16'd0, 16'hFFFF);
        send_item(1'b1, 32'd0);
        send_item(1'b0, 32'hFFFF_FFFF);
        send_item(1'b1, 32'd0);
        wait_idle();
        program_regs(5'b01110, 1'b1, 24'hFFFFFF, 24'd0, 16'd600, 16'd601);
        send_item(1'b0, 32'd999999);
        send_item(1'b1, 32'd0);
        send_item(1'b0, 32'd1000000);
        send_item(1'b1, 32'd0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct = (ph < 4) ? 6 : (ph < 8) ? 71 : 0;
            recv_idle_pct = (ph < 4) ? 71 : (ph < 8) ? 6 : 0;
            wait_idle();
            mask = (ph == 0) ? 5'b11111 : 5'($urandom());
            program_regs(mask, ($urandom_range(99) < 85),
                         ($urandom_range(3) == 0) ? 24'($urandom()) : rates[$urandom_range(8)],
                         ($urandom_range(3) == 0) ? 24'($urandom()) : bursts[$urandom_range(4)],
                         pick_ms(), pick_ms());
            // Long receiver hold-off while the sender keeps offering.
            if (ph == 5) hold_left = 400;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                run_window(used);
                sent += used;
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_latency_histogram_rate_governor_core passed");
        end else begin
            $display("tb_latency_histogram_rate_governor_core failed");
        end
        $finish;
    end

endmodule
